/* rtl/core/wmir_pkg.sv */
// Shared constants, codes and the command word type for the wavetable lookup block.
package wmir_pkg;

    localparam int FRAMES_DEF       = 64;
    localparam int SPF_DEF          = 2048;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic ACT_READ       = 1'b0;
    localparam logic ACT_WRITE      = 1'b1;

    localparam logic TABLE_BUILTIN  = 1'b0;
    localparam logic TABLE_LOADED   = 1'b1;

    // Morph of 1.0 in Q2.16.
    localparam logic [16:0] MORPH_ONE = 17'd65536;

    // Control part of one queued command word; addresses travel beside it.
    typedef struct packed {
        logic               is_write;
        logic               tbl;
        logic               odd;
        logic               top;
        logic               wr_ok;
        logic [15:0]        sfrac;
        logic [15:0]        ffrac;
        logic signed [15:0] wr_value;
    } t_cmd;

endpackage

/* rtl/core/wmir_front.sv */
// Front end: takes words, clamps morph, scales phase and builds table addresses.
module wmir_front import wmir_pkg::*; #(
    parameter int FRAMES            = FRAMES_DEF,
    parameter int SAMPLES_PER_FRAME = SPF_DEF,
    parameter int ROWW              = 5,
    parameter int IDXW              = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic               i_action,
    input  logic [31:0]        i_phase,
    input  logic signed [17:0] i_morph,
    input  logic               i_write_table,
    input  logic [5:0]         i_write_frame,
    input  logic [10:0]        i_write_index,
    input  logic signed [15:0] i_write_value,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd,
    output logic [ROWW-1:0]    o_row_a,
    output logic [ROWW-1:0]    o_row_b,
    output logic [IDXW-1:0]    o_idx,
    output logic [IDXW-1:0]    o_nidx
);

    localparam int FW  = $clog2(FRAMES);
    localparam int PW  = 32 + IDXW;
    localparam int FPW = 16 + FW;

    logic               r_v;
    logic               r_act;
    logic               r_tbl;
    logic [PW-1:0]      r_tp;
    logic [FPW-1:0]     r_fp;
    logic [5:0]         r_wframe;
    logic [10:0]        r_windex;
    logic signed [15:0] r_wvalue;

    logic               adv;
    logic               acc;
    logic [16:0]        mc;
    logic [FW-1:0]      fa;
    logic [IDXW-1:0]    idx;

    assign adv  = !r_v || !i_full;
    assign acc  = start && adv;
    assign busy = r_v && i_full;

    always_comb begin
        if (i_morph[17]) begin
            mc = '0;
        end else if (i_morph > $signed({1'b0, MORPH_ONE})) begin
            mc = MORPH_ONE;
        end else begin
            mc = 17'(i_morph);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_act    <= i_action;
            r_tbl    <= (i_action == ACT_WRITE) ? i_write_table : i_mode;
            r_tp     <= PW'(i_phase) * PW'(SAMPLES_PER_FRAME);
            r_fp     <= FPW'(mc) * FPW'(FRAMES - 1);
            r_wframe <= i_write_frame;
            r_windex <= i_write_index;
            r_wvalue <= i_write_value;
        end
    end

    // The integer part of the scaled phase is below the frame length by construction.
    assign idx = r_tp[32 +: IDXW];
    assign fa  = r_fp[16 +: FW];

    assign o_push = r_v && !i_full;

    always_comb begin
        o_cmd.is_write = r_act;
        o_cmd.tbl      = r_tbl;
        o_cmd.sfrac    = r_tp[31:16];
        o_cmd.ffrac    = r_fp[15:0];
        o_cmd.wr_value = r_wvalue;
        o_cmd.wr_ok    = (int'(r_wframe) < FRAMES) && (int'(r_windex) < SAMPLES_PER_FRAME);
        if (r_act == ACT_WRITE) begin
            o_cmd.odd = r_wframe[0];
            o_cmd.top = 1'b0;
            o_row_a   = ROWW'(r_wframe >> 1);
            o_row_b   = ROWW'(r_wframe >> 1);
            o_idx     = IDXW'(r_windex);
            o_nidx    = IDXW'(r_windex);
        end else begin
            o_cmd.odd = fa[0];
            // The upper frame only saturates at full morph, where its weight is zero.
            o_cmd.top = (fa == FW'(FRAMES - 1));
            o_row_a   = ROWW'({1'b0, fa} >> 1);
            o_row_b   = ROWW'(({1'b0, fa} + (FW + 1)'(1)) >> 1);
            o_idx     = idx;
            o_nidx    = (idx == IDXW'(SAMPLES_PER_FRAME - 1)) ? '0 : idx + IDXW'(1);
        end
    end

endmodule

/* rtl/core/wmir_queue.sv */
// Short queue of command words between the front end and the back end.
module wmir_queue import wmir_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wp;
    logic [PTRW-1:0]  r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             pop;

    // The back end never stalls, so the head word leaves as soon as it is there.
    assign pop     = (r_cnt != '0);
    assign o_valid = pop;
    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CNTW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTRW'(DEPTH - 1)) ? '0 : r_wp + PTRW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTRW'(DEPTH - 1)) ? '0 : r_rp + PTRW'(1);
            end
            r_cnt <= r_cnt + CNTW'(i_push) - CNTW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/core/wmir_back.sv */
// Back end: frame-banked sample memories and the bilinear interpolation pipe.
module wmir_back import wmir_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int ROWW        = 5,
    parameter int IDXW        = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cmd               i_cmd,
    input  logic [ROWW-1:0]    i_row_a,
    input  logic [ROWW-1:0]    i_row_b,
    input  logic [IDXW-1:0]    i_idx,
    input  logic [IDXW-1:0]    i_nidx,
    output logic               o_valid,
    output logic signed [15:0] o_sample_out
);

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = 1 + ROWW + IDXW;
    localparam int PRW  = SB + 18;
    localparam int WIDE = SB + 16;
    localparam int UPL  = (SB >= 16) ? SB - 16 : 0;
    localparam int DNL  = (SB < 16) ? 16 - SB : 0;

    // Even frames live in bank 0 and odd frames in bank 1, so the two frames of a
    // read always sit in different banks; each bank reads both neighbouring samples.
    logic [SB-1:0] r_bank0 [2**AW];
    logic [SB-1:0] r_bank1 [2**AW];

    logic [AW-1:0] addr0_i, addr0_n, addr1_i, addr1_n, waddr;
    logic [ROWW-1:0] row0, row1;
    logic signed [WIDE-1:0] wv;
    logic [SB-1:0] wconv;
    logic we0, we1;

    logic [SB-1:0] r_q0a, r_q0n, r_q1a, r_q1n;
    logic          r_v1, r_odd1, r_top1;
    logic [15:0]   r_sf1, r_ff1;

    logic signed [SB-1:0]  a0, a1, b0, b1;
    logic signed [SB:0]    da, db;
    logic signed [PRW-1:0] pa, pb;

    logic signed [SB-1:0]  r_a0, r_b0;
    logic signed [PRW-1:0] r_pa, r_pb;
    logic                  r_v2, r_top2;
    logic [15:0]           r_ff2;

    logic signed [SB-1:0]  sa, sb;
    logic signed [SB-1:0]  r_sa3, r_sb3;
    logic                  r_v3;
    logic [15:0]           r_ff3;

    logic signed [SB:0]    df;
    logic signed [PRW-1:0] pf;
    logic signed [SB-1:0]  r_sa4;
    logic signed [PRW-1:0] r_pf4;
    logic                  r_v4;

    logic signed [SB-1:0]   rs;
    logic signed [WIDE-1:0] rw;

    assign row0    = i_cmd.odd ? i_row_b : i_row_a;
    assign row1    = i_cmd.odd ? i_row_a : i_row_b;
    assign addr0_i = {i_cmd.tbl, row0, i_idx};
    assign addr0_n = {i_cmd.tbl, row0, i_nidx};
    assign addr1_i = {i_cmd.tbl, row1, i_idx};
    assign addr1_n = {i_cmd.tbl, row1, i_nidx};
    assign waddr   = {i_cmd.tbl, i_row_a, i_idx};

    assign wv    = WIDE'(i_cmd.wr_value);
    assign wconv = SB'((wv <<< UPL) >>> DNL);
    assign we0   = i_valid && i_cmd.is_write && i_cmd.wr_ok && !i_cmd.odd;
    assign we1   = i_valid && i_cmd.is_write && i_cmd.wr_ok && i_cmd.odd;

    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_bank0[waddr] <= wconv;
        end
        r_q0a <= r_bank0[addr0_i];
        r_q0n <= r_bank0[addr0_n];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_bank1[waddr] <= wconv;
        end
        r_q1a <= r_bank1[addr1_i];
        r_q1n <= r_bank1[addr1_n];
    end

    // Sample step, multiply half.
    assign a0 = r_odd1 ? r_q1a : r_q0a;
    assign a1 = r_odd1 ? r_q1n : r_q0n;
    assign b0 = r_odd1 ? r_q0a : r_q1a;
    assign b1 = r_odd1 ? r_q0n : r_q1n;
    assign da = (SB + 1)'(a1) - (SB + 1)'(a0);
    assign db = (SB + 1)'(b1) - (SB + 1)'(b0);
    assign pa = PRW'(da) * PRW'($signed({1'b0, r_sf1}));
    assign pb = PRW'(db) * PRW'($signed({1'b0, r_sf1}));

    // Sample step, add half; a saturated upper frame simply repeats the lower one.
    assign sa = SB'(PRW'(r_a0) + (r_pa >>> 16));
    assign sb = r_top2 ? sa : SB'(PRW'(r_b0) + (r_pb >>> 16));

    // Frame step.
    assign df = (SB + 1)'(r_sb3) - (SB + 1)'(r_sa3);
    assign pf = PRW'(df) * PRW'($signed({1'b0, r_ff3}));
    assign rs = SB'(PRW'(r_sa4) + (r_pf4 >>> 16));
    assign rw = WIDE'(rs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid && !i_cmd.is_write;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odd1       <= i_cmd.odd;
        r_top1       <= i_cmd.top;
        r_sf1        <= i_cmd.sfrac;
        r_ff1        <= i_cmd.ffrac;
        r_a0         <= a0;
        r_b0         <= b0;
        r_pa         <= pa;
        r_pb         <= pb;
        r_top2       <= r_top1;
        r_ff2        <= r_ff1;
        r_sa3        <= sa;
        r_sb3        <= sb;
        r_ff3        <= r_ff2;
        r_sa4        <= r_sa3;
        r_pf4        <= pf;
        o_sample_out <= 16'((rw >>> UPL) <<< DNL);
    end

endmodule

/* rtl/core/wavetable_morph_interp_read.sv */
// Top level of the two-table bilinear wavetable lookup.
//
// Input channel: a word is taken at a rising edge with start high and o_busy low.
// i_action selects a read (phase and morph) or a write of one table sample
// (table, frame, index, value). Writes outside the table size are dropped.
// Configuration: i_cfg_we writes i_cfg_data into the table mode register
// (0 built-in table, 1 loaded table), which later reads use.
// Result channel: o_valid is high for one cycle with o_sample_out for each read;
// writes give no result. The receiver takes every result and cannot hold it off.
// A read is registered in the front end, held in the queue, then passes the
// back-end registers in order. Throughput: one word per cycle, every cycle; the
// pipe has a fixed length and each frame-parity bank serves both neighbouring
// samples of a read in the same cycle, so o_busy stays low in operation.
// Reset: synchronous and active low; it empties the queue and the pipe and sets
// the mode to the built-in table. Table contents are not cleared and must be
// written before they are read.
module wavetable_morph_interp_read import wmir_pkg::*; #(
    parameter int FRAMES            = FRAMES_DEF,
    parameter int SAMPLES_PER_FRAME = SPF_DEF,
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_action,
    input  logic [31:0]        i_phase,
    input  logic signed [17:0] i_morph,
    input  logic               i_write_table,
    input  logic [5:0]         i_write_frame,
    input  logic [10:0]        i_write_index,
    input  logic signed [15:0] i_write_value,
    output logic               o_valid,
    output logic signed [15:0] o_sample_out
);

    localparam int ROWS = (FRAMES + 1) / 2;
    localparam int ROWW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDXW = $clog2(SAMPLES_PER_FRAME);
    localparam int QW   = $bits(t_cmd) + 2 * ROWW + 2 * IDXW;

    logic            r_mode;
    logic            push, full, q_valid;
    t_cmd            f_cmd, b_cmd;
    logic [ROWW-1:0] f_row_a, f_row_b, b_row_a, b_row_b;
    logic [IDXW-1:0] f_idx, f_nidx, b_idx, b_nidx;
    logic [QW-1:0]   q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= TABLE_BUILTIN;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    wmir_front #(
        .FRAMES            (FRAMES),
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME),
        .ROWW              (ROWW),
        .IDXW              (IDXW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (o_busy),
        .i_mode        (r_mode),
        .i_action      (i_action),
        .i_phase       (i_phase),
        .i_morph       (i_morph),
        .i_write_table (i_write_table),
        .i_write_frame (i_write_frame),
        .i_write_index (i_write_index),
        .i_write_value (i_write_value),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (f_cmd),
        .o_row_a       (f_row_a),
        .o_row_b       (f_row_b),
        .o_idx         (f_idx),
        .o_nidx        (f_nidx)
    );

    assign q_in = {f_cmd, f_row_a, f_row_b, f_idx, f_nidx};

    wmir_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_cmd, b_row_a, b_row_b, b_idx, b_nidx} = q_out;

    wmir_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ROWW        (ROWW),
        .IDXW        (IDXW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_cmd        (b_cmd),
        .i_row_a      (b_row_a),
        .i_row_b      (b_row_b),
        .i_idx        (b_idx),
        .i_nidx       (b_nidx),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

/* rtl/core/wmir_check.sv */
// Port-level checker for the wavetable lookup, bound to the top level.
module wmir_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic o_busy,
    input logic i_action,
    input logic o_valid
);

    // Reset empties the pipe, so no result word follows a reset cycle.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Every read word gives its result.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !o_busy && !i_action) |-> ##7 o_valid)
        else $error("read word lost or late");

    // A write word occupies its slot without producing a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !o_busy && i_action) |-> ##7 !o_valid)
        else $error("write word produced a result");

    // No result appears without a matching read word before it.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !o_busy && !i_action, 7))
        else $error("result without a matching read word");

endmodule

bind wavetable_morph_interp_read wmir_check u_check (.*);
